// ----- sv/hss_pkg.sv -----
// Package for the harmonic sine series block: sizes, fixed-point constants,
// item and status types, and the CORDIC arctangent and saturation helpers.
// No dependencies.
`default_nettype none
package hss_pkg;
   localparam int MAX_HARMONICS = 64;
   localparam int CORDIC_STEPS = 24;
   localparam int IDX_W = $clog2(MAX_HARMONICS);
   localparam int CNT_W = $clog2(MAX_HARMONICS + 1);
   localparam int STEP_W = $clog2(CORDIC_STEPS);

   localparam logic [42:0] TWO_PI_Q40 = 43'h6487ED5110B;
   localparam logic signed [34:0] PI_Q30 = 35'sh0C90FDAA2;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sh06487ED51;
   localparam logic signed [34:0] TWO_PI_Q30 = 35'sh1921FB544;
   localparam logic signed [34:0] GAIN_Q30 = 35'sh026DD3B6A;
   // Reciprocal of two pi as 2^74 / TWO_PI_Q40, rounded down by a few units
   // so that the quotient estimate never exceeds the true quotient.
   localparam logic [31:0] INV_TWO_PI = 32'd2734261100;

   localparam logic [1:0] CSR_OMEGA = 2'd0;
   localparam logic [1:0] CSR_HARMONICS = 2'd1;
   localparam logic REQ_LOAD = 1'b0;

   typedef struct packed {
      logic        req_type;
      logic [5:0]  coef_index;
      logic [31:0] coef_value;
      logic [31:0] sample_time;
   } req_item_type;

   typedef struct packed {
      logic [31:0] series_value;
      logic [31:0] series_derivative;
   } rsp_item_type;

   typedef struct packed {
      logic busy;
   } back_status_type;

   function automatic logic signed [34:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [34:0] r;
      case (i)
         0: r = 35'sd843314857;
         1: r = 35'sd497837829;
         2: r = 35'sd263043837;
         3: r = 35'sd133525159;
         4: r = 35'sd67021687;
         5: r = 35'sd33543515;
         6: r = 35'sd16775851;
         7: r = 35'sd8388437;
         8: r = 35'sd4194283;
         9: r = 35'sd2097149;
         10: r = 35'sd1048576;
         default: begin
            if (32'(i) <= 30) r = 35'sd1 <<< (30 - 32'(i));
            else r = '0;
         end
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) r = 32'h7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'h80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- sv/hss_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module hss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- sv/hss_queue.sv -----
// Two-entry queue of sample times between the front and the back.
// Depends on hss_pkg.
`default_nettype none
module hss_queue import hss_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire logic [31:0] push_data,
   input  wire logic        pop,
   output logic [31:0]      pop_data,
   output logic             empty,
   output logic             full
);
   logic [31:0] data_ff [2];
   logic [1:0] count_ff, count_in;
   logic rd_ff, rd_in, wr_ff, wr_in;

   assign empty = (count_ff == 2'd0);
   assign full = (count_ff == 2'd2);
   assign pop_data = data_ff[rd_ff];

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) data_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ----- sv/hss_front.sv -----
// Front end: accepts items, writes loads into the coefficient table, queues
// samples, and holds the configuration registers. Depends on hss_pkg.
`default_nettype none
module hss_front import hss_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_item_type       req_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire back_status_type    back_status,
   input  wire logic               q_empty,
   input  wire logic               q_full,
   output logic                    q_push,
   output logic                    wr_en,
   output logic [IDX_W-1:0]        wr_addr,
   output logic [31:0]             wr_data,
   output logic [MAX_HARMONICS-1:0] coef_valid,
   output logic [31:0]             omega,
   output logic [CNT_W-1:0]        harm_count
);
   logic [MAX_HARMONICS-1:0] valid_ff, valid_in;
   logic [31:0] omega_ff;
   logic [6:0] harm_ff;
   logic is_load, accept;

   assign is_load = (req_data.req_type == REQ_LOAD);
   assign req_stall = is_load ? (back_status.busy || !q_empty) : q_full;
   assign accept = req_valid && !req_stall;
   assign q_push = accept && !is_load;
   assign wr_en = accept && is_load && (32'(req_data.coef_index) < MAX_HARMONICS);
   assign wr_addr = req_data.coef_index[IDX_W-1:0];
   assign wr_data = req_data.coef_value;
   assign coef_valid = valid_ff;
   assign csr_ready = 1'b1;
   assign omega = omega_ff;
   assign harm_count = (32'(harm_ff) > MAX_HARMONICS) ? CNT_W'(MAX_HARMONICS)
                                                      : CNT_W'(harm_ff);

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) valid_in[wr_addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         omega_ff <= 32'd16777216;
         harm_ff <= 7'd1;
      end else begin
         valid_ff <= valid_in;
         if (csr_valid && csr_index == CSR_OMEGA) omega_ff <= csr_data;
         if (csr_valid && csr_index == CSR_HARMONICS) harm_ff <= csr_data[6:0];
      end
   end
endmodule
`default_nettype wire

// ----- sv/hss_back.sv -----
// Back end: sequencer that reduces the phase step, walks the harmonics with
// an iterative CORDIC, accumulates both sums and holds the result register.
// Depends on hss_pkg.
`default_nettype none
module hss_back import hss_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire logic [31:0]         q_data,
   output logic                     q_pop,
   input  wire logic [31:0]         omega,
   input  wire logic [CNT_W-1:0]    harm_count,
   input  wire logic [MAX_HARMONICS-1:0] coef_valid,
   output logic [IDX_W-1:0]         rd_addr,
   input  wire logic [31:0]         rd_data,
   output back_status_type          status,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_item_type             rsp_data
);
   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_MULT  = 12'b000000000010,
      ST_QEST  = 12'b000000000100,
      ST_QMUL  = 12'b000000001000,
      ST_SUB   = 12'b000000010000,
      ST_CORR  = 12'b000000100000,
      ST_FIX   = 12'b000001000000,
      ST_PHASE = 12'b000010000000,
      ST_ROT   = 12'b000100000000,
      ST_PROD  = 12'b001000000000,
      ST_SCALE = 12'b010000000000,
      ST_DONE  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] mag_ff;
   logic [63:0] prod_ff;
   logic [20:0] q_ff;
   logic [42:0] qmh_ff;
   logic [41:0] qml_ff;
   logic [63:0] rem_ff;
   logic neg_ff;
   logic [42:0] r_ff, phase_ff;
   logic [CNT_W-1:0] k_ff;
   logic [STEP_W-1:0] i_ff;
   logic signed [34:0] x_ff, y_ff, z_ff;
   logic flip_ff;
   logic signed [66:0] pv_ff, pc_ff;
   logic signed [64:0] pw_ff;
   logic signed [63:0] sum_v_ff, sum_d_ff;
   logic rsp_valid_ff;
   logic pend_ff;
   rsp_item_type rsp_ff;

   logic [63:0] qprod;
   logic [43:0] phase_sum;
   logic [42:0] phase_nx;
   logic signed [34:0] ang, ang_f, dx, dy, at, cosv;
   logic ang_flip;
   logic signed [31:0] coef;
   logic signed [66:0] pv_r, pc_r;
   logic [31:0] w;
   logic signed [64:0] pw_r;
   logic signed [40:0] dterm;
   logic signed [48:0] dk;
   logic out_free, done_go;

   assign status.busy = (state_ff != ST_IDLE);
   assign q_pop = (state_ff == ST_IDLE) && !q_empty;
   assign rd_addr = IDX_W'(k_ff - CNT_W'(1));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign done_go = out_free && !pend_ff;

   always_comb begin
      qprod = prod_ff[63:32] * INV_TWO_PI;
      phase_sum = {1'b0, phase_ff} + {1'b0, r_ff};
      phase_nx = (phase_sum >= {1'b0, TWO_PI_Q40}) ? 43'(phase_sum - {1'b0, TWO_PI_Q40})
                                                   : phase_sum[42:0];
      ang = $signed({2'b00, phase_nx[42:10]});
      if (ang >= PI_Q30) ang = ang - TWO_PI_Q30;
      ang_flip = 1'b0;
      ang_f = ang;
      if (ang > HALF_PI_Q30) begin
         ang_f = PI_Q30 - ang;
         ang_flip = 1'b1;
      end else if (ang < -HALF_PI_Q30) begin
         ang_f = -PI_Q30 - ang;
         ang_flip = 1'b1;
      end
      dx = y_ff >>> i_ff;
      dy = x_ff >>> i_ff;
      at = atan_entry(i_ff);
      coef = coef_valid[rd_addr] ? $signed(rd_data) : 32'sd0;
      cosv = flip_ff ? -x_ff : x_ff;
      pv_r = (pv_ff + 67'sd536870912) >>> 30;
      pc_r = (pc_ff + 67'sd536870912) >>> 30;
      w = sat32(64'(pc_r));
      pw_r = (pw_ff + 65'sd8388608) >>> 24;
      dterm = pw_r[40:0];
      dk = dterm * $signed({1'b0, k_ff});
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_MULT;
         ST_MULT: state_in = ST_QEST;
         ST_QEST: state_in = ST_QMUL;
         ST_QMUL: state_in = ST_SUB;
         ST_SUB: state_in = ST_CORR;
         ST_CORR: state_in = ST_FIX;
         ST_FIX: state_in = (harm_count == '0) ? ST_DONE : ST_PHASE;
         ST_PHASE: state_in = ST_ROT;
         ST_ROT: if (32'(i_ff) == CORDIC_STEPS - 1) state_in = ST_PROD;
         ST_PROD: state_in = ST_SCALE;
         ST_SCALE: state_in = (k_ff == harm_count) ? ST_DONE : ST_PHASE;
         ST_DONE: if (done_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= (state_ff == ST_SCALE);
         if (state_ff == ST_DONE && done_go) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            mag_ff <= q_data[31] ? -q_data : q_data;
            neg_ff <= q_data[31];
         end
         ST_MULT: prod_ff <= {32'd0, omega} * {32'd0, mag_ff};
         ST_QEST: q_ff <= qprod[62:42];
         ST_QMUL: begin
            qmh_ff <= {22'd0, q_ff} * {21'd0, TWO_PI_Q40[42:21]};
            qml_ff <= {21'd0, q_ff} * {21'd0, TWO_PI_Q40[20:0]};
         end
         ST_SUB: rem_ff <= prod_ff - ({qmh_ff, 21'd0} + {22'd0, qml_ff});
         ST_CORR: begin
            if (rem_ff >= {21'd0, TWO_PI_Q40}) rem_ff <= rem_ff - {21'd0, TWO_PI_Q40};
         end
         ST_FIX: begin
            r_ff <= (neg_ff && rem_ff != '0) ? 43'(TWO_PI_Q40 - rem_ff[42:0]) : rem_ff[42:0];
            phase_ff <= '0;
            k_ff <= CNT_W'(1);
            sum_v_ff <= '0;
            sum_d_ff <= '0;
         end
         ST_PHASE: begin
            phase_ff <= phase_nx;
            x_ff <= GAIN_Q30;
            y_ff <= '0;
            z_ff <= ang_f;
            flip_ff <= ang_flip;
            i_ff <= '0;
         end
         ST_ROT: begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end
            i_ff <= i_ff + STEP_W'(1);
         end
         ST_PROD: begin
            pv_ff <= 67'(coef * y_ff);
            pc_ff <= 67'(coef * cosv);
         end
         ST_SCALE: begin
            sum_v_ff <= sum_v_ff + 64'(pv_r);
            pw_ff <= $signed(w) * $signed({1'b0, omega});
         end
         ST_DONE: if (done_go) begin
            rsp_ff.series_value <= sat32(sum_v_ff);
            rsp_ff.series_derivative <= sat32(sum_d_ff);
         end
         default: ;
      endcase
      // The derivative term of a harmonic is added in the cycle after its scale
      // step, while the next phase is formed or before the result is taken.
      if (pend_ff) begin
         sum_d_ff <= sum_d_ff + 64'(dk);
         k_ff <= k_ff + CNT_W'(1);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT) |-> (32'(i_ff) < CORDIC_STEPS))
      else $error("CORDIC step counter past its last step");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE) |-> (k_ff <= harm_count && k_ff != '0))
      else $error("harmonic counter out of range");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_MULT))
      else $error("popped sample did not start the sequencer");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> (rem_ff < {21'd0, TWO_PI_Q40}))
      else $error("phase step remainder not reduced below two pi");
endmodule
`default_nettype wire

// ----- sv/harmonic_sine_sum_with_derivative.sv -----
// Sine series with time derivative. Each sample runs a phase-step reduction, then
// per harmonic a phase step, 24 CORDIC rotations, a product and a scale step;
// with no harmonics it goes straight to the result. A queued sample starts only
// after the prior sample is done; loads need an idle back end and an empty queue.
// Synchronous reset clears the coefficient table valid bits and sets the
// registers to omega = 1.0 and one harmonic; no clearing pass is needed.
`default_nettype none
module harmonic_sine_sum_with_derivative import hss_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);
   back_status_type back_status;
   logic q_empty, q_full, q_push, q_pop;
   logic [31:0] q_data;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data, omega;
   logic [MAX_HARMONICS-1:0] coef_valid;
   logic [CNT_W-1:0] harm_count;

   hss_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .back_status, .q_empty, .q_full, .q_push,
      .wr_en, .wr_addr, .wr_data, .coef_valid, .omega, .harm_count
   );

   hss_queue u_queue (
      .clock, .reset, .push(q_push), .push_data(req_data.sample_time),
      .pop(q_pop), .pop_data(q_data), .empty(q_empty), .full(q_full)
   );

   hss_ram #(.WIDTH(32), .DEPTH(MAX_HARMONICS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   hss_back u_back (
      .clock, .reset, .q_empty, .q_data, .q_pop, .omega, .harm_count,
      .coef_valid, .rd_addr, .rd_data, .status(back_status),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire

// ----- test/tb_harmonic_sine_sum_with_derivative.sv -----
// Testbench for the harmonic sine series block: random and directed loads and samples,
// checked against a bit-exact fixed-point predictor held in a small scoreboard class.
// Depends on hss_pkg and harmonic_sine_sum_with_derivative.
`timescale 1ns / 1ps
module tb_harmonic_sine_sum_with_derivative;
   import hss_pkg::*;

   localparam logic REQ_SAMPLE = 1'b1;
   localparam int STALL_LIMIT = 60000;
   localparam longint TWO_PI_PHASE = 64'h6487ED5110B;
   localparam longint PI_ANGLE = 64'hC90FDAA2;
   localparam longint HALF_PI_ANGLE = 64'h6487ED51;
   localparam longint TWO_PI_ANGLE = 64'h1921FB544;
   localparam longint CORDIC_START = 64'h26DD3B6A;

   class series_scoreboard;
      logic [31:0] omega;
      logic [6:0] harmonic_count;
      logic signed [31:0] coefs[64];
      rsp_item_type expected_sums[$];
      int errors;
      int samples;
      int loads;

      function new();
         omega = 32'h0100_0000;
         harmonic_count = 7'd1;
         foreach (coefs[i]) coefs[i] = '0;
         errors = 0;
         samples = 0;
         loads = 0;
      endfunction

      function void set_reg(logic [1:0] index, logic [31:0] value);
         if (index == CSR_OMEGA) omega = value;
         else if (index == CSR_HARMONICS) harmonic_count = value[6:0];
      endfunction

      function longint arctan_step(int i);
         longint tbl[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543515, 16775851, 8388437, 4194283, 2097149, 1048576};
         if (i < 11) return tbl[i];
         if (i <= 30) return longint'(1) << (30 - i);
         return 0;
      endfunction

      function longint round_q(longint v, int s);
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function void sin_cos(longint phase, output longint s, output longint c);
         longint a, x, y, z, dx, dy;
         bit flip;
         a = phase >>> 10;
         flip = 0;
         if (a >= PI_ANGLE) a -= TWO_PI_ANGLE;
         if (a > HALF_PI_ANGLE) begin
            a = PI_ANGLE - a;
            flip = 1;
         end else if (a < -HALF_PI_ANGLE) begin
            a = -PI_ANGLE - a;
            flip = 1;
         end
         x = CORDIC_START;
         y = 0;
         z = a;
         for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= arctan_step(i);
            end else begin
               x += dx;
               y -= dy;
               z += arctan_step(i);
            end
         end
         s = y;
         c = flip ? -x : x;
      endfunction

      function void note_item(req_item_type item);
         longint t, w_om, step, phase, sum_v, sum_d, s, c, w, coef;
         int n;
         rsp_item_type sums;
         if (item.req_type == REQ_LOAD) begin
            coefs[item.coef_index] = item.coef_value;
            loads++;
            return;
         end
         samples++;
         t = longint'(signed'(item.sample_time));
         w_om = longint'({32'd0, omega});
         n = (harmonic_count > 64) ? 64 : int'(harmonic_count);
         step = (w_om * t) % TWO_PI_PHASE;
         if (step < 0) step += TWO_PI_PHASE;
         phase = 0;
         sum_v = 0;
         sum_d = 0;
         for (int k = 1; k <= n; k++) begin
            coef = longint'(coefs[k - 1]);
            phase += step;
            if (phase >= TWO_PI_PHASE) phase -= TWO_PI_PHASE;
            sin_cos(phase, s, c);
            sum_v += round_q(coef * s, 30);
            w = clamp32(round_q(coef * c, 30));
            sum_d += longint'(k) * round_q(w * w_om, 24);
         end
         sums.series_value = 32'(clamp32(sum_v));
         sums.series_derivative = 32'(clamp32(sum_d));
         expected_sums.push_back(sums);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
         errors++;
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_sums.size() == 0) begin
            report("unexpected result, series_value", got.series_value, 'x);
            return;
         end
         want = expected_sums.pop_front();
         if (got.series_value !== want.series_value)
            report("series_value", got.series_value, want.series_value);
         if (got.series_derivative !== want.series_derivative)
            report("series_derivative", got.series_derivative, want.series_derivative);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   rsp_item_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   series_scoreboard sb = new();
   int send_pct = 0;
   int stall_pct = 0;
   bit hold_request = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int phases_run = 0;

   always #6 clock = ~clock;

   harmonic_sine_sum_with_derivative dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (hold_request) hold_left <= 3000;
      rsp_stall <= (hold_left > 1) || (hold_request && hold_left == 0)
                   || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task send_item(req_item_type item);
      if ($urandom_range(99) < send_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_pct);
      end
      req_valid <= 1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      sb.note_item(item);
   endtask

   task write_reg(logic [1:0] index, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.set_reg(index, value);
      @(posedge clock);
   endtask

   task drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.expected_sums.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function req_item_type random_item(int sample_pct);
      req_item_type item;
      item.req_type = ($urandom_range(99) < sample_pct) ? REQ_SAMPLE : REQ_LOAD;
      item.coef_index = 6'($urandom_range(63));
      item.coef_value = $urandom_range(1) ? $urandom : 32'($signed($urandom_range(2097151)) - 1048576);
      item.sample_time = $urandom_range(1) ? $urandom : 32'($signed($urandom_range(1048575)) - 524288);
      return item;
   endfunction

   function req_item_type make_item(logic kind, int index, logic [31:0] coef, logic [31:0] t);
      req_item_type item;
      item.req_type = kind;
      item.coef_index = 6'(index);
      item.coef_value = coef;
      item.sample_time = t;
      return item;
   endfunction

   initial begin
      logic [31:0] omegas[8] = '{32'hFFFF_FFFF, 32'h0, 32'h0192_1FB5, 32'h0100_0000,
                                 32'h8000_0000, 32'h0003_2000, 32'h0064_87ED, 32'h1234_5678};
      logic [6:0] counts[8] = '{7'd127, 7'd0, 7'd64, 7'd3, 7'd1, 7'd8, 7'd5, 7'd2};
      int idle_modes[4][2] = '{'{0, 0}, '{82, 0}, '{0, 82}, '{22, 22}};
      int items_per_phase;

      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(make_item(REQ_SAMPLE, 0, 0, 32'h0001_0000));
      send_item(make_item(REQ_LOAD, 0, 32'h7FFF_FFFF, 0));
      send_item(make_item(REQ_SAMPLE, 0, 0, 32'h0001_0000));
      send_item(make_item(REQ_SAMPLE, 0, 0, 32'h0));
      send_item(make_item(REQ_SAMPLE, 0, 0, 32'h7FFF_FFFF));
      send_item(make_item(REQ_SAMPLE, 0, 0, 32'h8000_0000));
      send_item(make_item(REQ_SAMPLE, 0, 0, 32'hFFFF_FFFF));
      send_item(make_item(REQ_LOAD, 0, 32'h8000_0000, 0));
      send_item(make_item(REQ_SAMPLE, 0, 0, 32'h0001_9220));
      send_item(make_item(REQ_LOAD, 63, 32'h7FFF_FFFF, 0));
      send_item(make_item(REQ_LOAD, 1, 32'h0001_0000, 0));
      send_item(make_item(REQ_LOAD, 2, 32'hFFFF_0000, 0));
      drain();
      write_reg(CSR_HARMONICS, 32'd64);
      send_item(make_item(REQ_SAMPLE, 0, 0, 32'h0000_C910));
      send_item(make_item(REQ_SAMPLE, 0, 0, 32'hFFFF_36F0));
      send_item(make_item(REQ_SAMPLE, 0, 0, 32'h8000_0000));

      for (int p = 0; p < 8; p++) begin
         drain();
         write_reg(CSR_OMEGA, omegas[p]);
         write_reg(CSR_HARMONICS, {25'd0, counts[p]});
         send_pct = idle_modes[p % 4][0];
         stall_pct = idle_modes[p % 4][1];
         items_per_phase = (counts[p] > 16) ? 30 : 80;
         if (p == 3) hold_request = 1;
         for (int i = 0; i < items_per_phase; i++) begin
            send_item(random_item(50));
            if (hold_request && hold_left > 0) hold_request = 0;
         end
         hold_request = 0;
         phases_run++;
      end

      drain();
      $display("Covered %0d samples and %0d coefficient loads over %0d register settings,",
               sb.samples, sb.loads, phases_run + 1);
      $display("with sender gaps, receiver stalls and one long receiver hold.");
      if (sb.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

// ----- sim.f -----
sv/hss_pkg.sv
sv/hss_ram.sv
sv/hss_queue.sv
sv/hss_front.sv
sv/hss_back.sv
sv/harmonic_sine_sum_with_derivative.sv
test/tb_harmonic_sine_sum_with_derivative.sv
